// ===== rtl/hsv2rgb_pkg.sv =====
// Shared types and constants of the HSV to RGB pixel converter.
package hsv2rgb_pkg;

	localparam int unsigned HUE_W      = 13;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned SECTOR_W   = 3;
	localparam int unsigned K_W        = 10;
	localparam int unsigned PROD_W     = 2 * CHAN_W;
	localparam int unsigned TERM_W     = 26;
	localparam int unsigned NUM_W      = 27;
	localparam int unsigned RECIP_W    = 27;
	localparam int unsigned SCALE_W    = NUM_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 44;
	localparam int unsigned QUO_W      = SCALE_W - RECIP_SHIFT;
	localparam int unsigned NUM_LANES  = 3;

	localparam int unsigned HUE_FULL    = 5760;
	localparam int unsigned SECTOR_LEN  = 960;
	localparam int unsigned NUM_SECTORS = 6;
	localparam int unsigned CHAN_MAX    = 255;
	localparam int unsigned DENOM       = CHAN_MAX * SECTOR_LEN;
	localparam int unsigned HALF_DENOM  = DENOM / 2;
	localparam int unsigned NUM_LIMIT   = 1 << (NUM_W - 1);

	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) / 64'(DENOM)) + 64'd1;
	localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_FULL);

	localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;
	localparam logic [SECTOR_W-1:0] SEC_MAGENTA_RED   = 3'd5;

	localparam int unsigned LANE_RED   = 0;
	localparam int unsigned LANE_GREEN = 1;
	localparam int unsigned LANE_BLUE  = 2;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [K_W-1:0]      k;
		logic [PROD_W-1:0]   prod;
		logic [CHAN_W-1:0]   val;
	} sect_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [TERM_W-1:0]   cn;
		logic [TERM_W-1:0]   xn;
		logic [TERM_W-1:0]   mn;
	} term_t;

endpackage

// ===== rtl/hsv2rgb_stream_if.sv =====
// Valid/ready stream channel carrying one payload word.
interface hsv2rgb_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hsv2rgb_converter_top.sv =====
// Top level of the HSV to RGB pixel converter.
//
//   channel  dir  word                               handshake
//   hsv      in   hue[12:0] saturation[7:0] brightness[7:0]  valid/ready
//   rgb      out  red[7:0] green[7:0] blue[7:0]      valid/ready
//
// One word per cycle sustained while rgb.ready stays high; rgb.valid is the valid bit of the last stage.
// Four register stages: sector split, multipliers, channel placement, reciprocal scaling.
// arst_n clears all valid bits; payload registers are not reset.
// Each stage holds while its successor is full and stalled; bubbles are absorbed.
module hsv_to_rgb_converter_top (
	input  logic       clk,
	input  logic       arst_n,
	hsv2rgb_stream_if.sink   hsv,
	hsv2rgb_stream_if.source rgb
);

	logic                s1_valid;
	logic                s1_ready;
	hsv2rgb_pkg::sect_t  s1_data;
	logic                s2_valid;
	logic                s2_ready;
	hsv2rgb_pkg::term_t  s2_data;
	hsv2rgb_pkg::hsv_t   hsv_word;
	hsv2rgb_pkg::rgb_t   rgb_word;

	assign hsv_word.hue        = hsv.data.hue;
	assign hsv_word.saturation = hsv.data.saturation;
	assign hsv_word.brightness = hsv.data.brightness;

	hsv2rgb_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (hsv.valid),
		.up_ready (hsv.ready),
		.up_data  (hsv_word),
		.dn_valid (s1_valid),
		.dn_ready (s1_ready),
		.dn_data  (s1_data)
	);

	hsv2rgb_product u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s1_valid),
		.up_ready (s1_ready),
		.up_data  (s1_data),
		.dn_valid (s2_valid),
		.dn_ready (s2_ready),
		.dn_data  (s2_data)
	);

	hsv2rgb_channel u_channel (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s2_valid),
		.up_ready (s2_ready),
		.up_data  (s2_data),
		.dn_valid (rgb.valid),
		.dn_ready (rgb.ready),
		.dn_data  (rgb_word)
	);

	assign rgb.data.red   = rgb_word.red;
	assign rgb.data.green = rgb_word.green;
	assign rgb.data.blue  = rgb_word.blue;

endmodule

// ===== rtl/hsv2rgb_sector.sv =====
// Stage 1: hue wrap, sector and in-sector position, value times saturation.
module hsv2rgb_sector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  hsv2rgb_pkg::hsv_t   up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output hsv2rgb_pkg::sect_t  dn_data
);

	logic                                 valid_s1;
	hsv2rgb_pkg::sect_t                   data_s1;
	logic [hsv2rgb_pkg::HUE_W-1:0]        hue_w;
	logic [hsv2rgb_pkg::HUE_W-1:0]        base;
	logic [hsv2rgb_pkg::HUE_W-1:0]        offset;
	logic [hsv2rgb_pkg::SECTOR_W-1:0]     sector;
	logic [hsv2rgb_pkg::K_W-1:0]          pos;
	logic [hsv2rgb_pkg::K_W-1:0]          k;
	logic [hsv2rgb_pkg::PROD_W-1:0]       prod;

	always_comb begin
		if (up_data.hue >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_FULL)) begin
			hue_w = up_data.hue - hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_FULL);
		end else begin
			hue_w = up_data.hue;
		end
		sector = '0;
		base   = '0;
		for (int i = 1; i < hsv2rgb_pkg::NUM_SECTORS; i++) begin
			if (hue_w >= hsv2rgb_pkg::HUE_W'(i * hsv2rgb_pkg::SECTOR_LEN)) begin
				sector = hsv2rgb_pkg::SECTOR_W'(i);
				base   = hsv2rgb_pkg::HUE_W'(i * hsv2rgb_pkg::SECTOR_LEN);
			end
		end
		offset = hue_w - base;
		pos    = offset[hsv2rgb_pkg::K_W-1:0];
		if (sector[0]) begin
			k = hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTOR_LEN) - pos;
		end else begin
			k = pos;
		end
		prod = hsv2rgb_pkg::PROD_W'(up_data.brightness)
			* hsv2rgb_pkg::PROD_W'(up_data.saturation);
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1.sector <= sector;
			data_s1.k      <= k;
			data_s1.prod   <= prod;
			data_s1.val    <= up_data.brightness;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> data_s1.sector <= hsv2rgb_pkg::SEC_MAGENTA_RED)
		else $error("sector out of range");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> data_s1.k <= hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTOR_LEN))
		else $error("sector position out of range");

endmodule

// ===== rtl/hsv2rgb_product.sv =====
// Stage 2: chroma, second component and offset terms over the common denominator.
module hsv2rgb_product (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  hsv2rgb_pkg::sect_t  up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output hsv2rgb_pkg::term_t  dn_data
);

	logic                                valid_s2;
	hsv2rgb_pkg::term_t                  data_s2;
	logic [hsv2rgb_pkg::PROD_W-1:0]      diff;
	logic [hsv2rgb_pkg::TERM_W-1:0]      cn;
	logic [hsv2rgb_pkg::TERM_W-1:0]      xn;
	logic [hsv2rgb_pkg::TERM_W-1:0]      mn;

	always_comb begin
		diff = (hsv2rgb_pkg::PROD_W'(up_data.val) << hsv2rgb_pkg::CHAN_W)
			- hsv2rgb_pkg::PROD_W'(up_data.val) - up_data.prod;
		cn = hsv2rgb_pkg::TERM_W'(up_data.prod)
			* hsv2rgb_pkg::TERM_W'(hsv2rgb_pkg::SECTOR_LEN);
		xn = hsv2rgb_pkg::TERM_W'(up_data.prod) * hsv2rgb_pkg::TERM_W'(up_data.k);
		mn = hsv2rgb_pkg::TERM_W'(diff)
			* hsv2rgb_pkg::TERM_W'(hsv2rgb_pkg::SECTOR_LEN);
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s2.sector <= up_data.sector;
			data_s2.cn     <= cn;
			data_s2.xn     <= xn;
			data_s2.mn     <= mn;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

	a_x_below_c: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> data_s2.xn <= data_s2.cn)
		else $error("second component exceeds chroma");

	a_c_plus_m: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (hsv2rgb_pkg::NUM_W'(data_s2.cn) + hsv2rgb_pkg::NUM_W'(data_s2.mn))
			<= hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::DENOM * hsv2rgb_pkg::CHAN_MAX))
		else $error("chroma plus offset exceeds full scale");

endmodule

// ===== rtl/hsv2rgb_channel.sv =====
// Stages 3 and 4: sector placement, offset and rounding, scale to 8-bit channels.
module hsv2rgb_channel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  hsv2rgb_pkg::term_t  up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output hsv2rgb_pkg::rgb_t   dn_data
);

	logic                                valid_s3;
	logic                                valid_s4;
	logic                                ready_s4;
	logic [hsv2rgb_pkg::NUM_W-1:0]       num_s3 [hsv2rgb_pkg::NUM_LANES];
	logic [hsv2rgb_pkg::TERM_W-1:0]      sel    [hsv2rgb_pkg::NUM_LANES];
	logic [hsv2rgb_pkg::NUM_W-1:0]       num    [hsv2rgb_pkg::NUM_LANES];
	logic [hsv2rgb_pkg::SCALE_W-1:0]     scaled [hsv2rgb_pkg::NUM_LANES];
	logic [hsv2rgb_pkg::QUO_W-1:0]       quo    [hsv2rgb_pkg::NUM_LANES];
	logic [hsv2rgb_pkg::CHAN_W-1:0]      chan   [hsv2rgb_pkg::NUM_LANES];
	hsv2rgb_pkg::rgb_t                   rgb_s4;

	always_comb begin
		case (up_data.sector)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				sel[hsv2rgb_pkg::LANE_RED]   = up_data.cn;
				sel[hsv2rgb_pkg::LANE_GREEN] = up_data.xn;
				sel[hsv2rgb_pkg::LANE_BLUE]  = '0;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				sel[hsv2rgb_pkg::LANE_RED]   = up_data.xn;
				sel[hsv2rgb_pkg::LANE_GREEN] = up_data.cn;
				sel[hsv2rgb_pkg::LANE_BLUE]  = '0;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				sel[hsv2rgb_pkg::LANE_RED]   = '0;
				sel[hsv2rgb_pkg::LANE_GREEN] = up_data.cn;
				sel[hsv2rgb_pkg::LANE_BLUE]  = up_data.xn;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				sel[hsv2rgb_pkg::LANE_RED]   = '0;
				sel[hsv2rgb_pkg::LANE_GREEN] = up_data.xn;
				sel[hsv2rgb_pkg::LANE_BLUE]  = up_data.cn;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				sel[hsv2rgb_pkg::LANE_RED]   = up_data.xn;
				sel[hsv2rgb_pkg::LANE_GREEN] = '0;
				sel[hsv2rgb_pkg::LANE_BLUE]  = up_data.cn;
			end
			default: begin
				sel[hsv2rgb_pkg::LANE_RED]   = up_data.cn;
				sel[hsv2rgb_pkg::LANE_GREEN] = '0;
				sel[hsv2rgb_pkg::LANE_BLUE]  = up_data.xn;
			end
		endcase
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			num[i] = hsv2rgb_pkg::NUM_W'(sel[i]) + hsv2rgb_pkg::NUM_W'(up_data.mn)
				+ hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::HALF_DENOM);
		end
	end

	always_comb begin
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			scaled[i] = hsv2rgb_pkg::SCALE_W'(num_s3[i])
				* hsv2rgb_pkg::SCALE_W'(hsv2rgb_pkg::RECIP_MULT);
			quo[i] = scaled[i][hsv2rgb_pkg::SCALE_W-1:hsv2rgb_pkg::RECIP_SHIFT];
			if (quo[i] > hsv2rgb_pkg::QUO_W'(hsv2rgb_pkg::CHAN_MAX)) begin
				chan[i] = hsv2rgb_pkg::CHAN_W'(hsv2rgb_pkg::CHAN_MAX);
			end else begin
				chan[i] = quo[i][hsv2rgb_pkg::CHAN_W-1:0];
			end
		end
	end

	assign ready_s4 = !valid_s4 || dn_ready;
	assign up_ready = !valid_s3 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (up_ready) begin
				valid_s3 <= up_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			num_s3 <= num;
		end
		if (valid_s3 && ready_s4) begin
			rgb_s4.red   <= chan[hsv2rgb_pkg::LANE_RED];
			rgb_s4.green <= chan[hsv2rgb_pkg::LANE_GREEN];
			rgb_s4.blue  <= chan[hsv2rgb_pkg::LANE_BLUE];
		end
	end

	assign dn_valid = valid_s4;
	assign dn_data  = rgb_s4;

	a_num_exact: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (num_s3[hsv2rgb_pkg::LANE_RED] < hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::NUM_LIMIT)
			&& num_s3[hsv2rgb_pkg::LANE_GREEN] < hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::NUM_LIMIT)
			&& num_s3[hsv2rgb_pkg::LANE_BLUE] < hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::NUM_LIMIT)))
		else $error("channel numerator outside exact scaling range");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the HSV to RGB pixel converter: directed table, then random pixels.
module testbench;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 11;
	localparam int PHASE_PIXELS   = 463;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam bit KNOWN          = 1'b1;
	localparam bit PREDICTED      = 1'b0;

	typedef struct packed {
		hsv2rgb_pkg::hsv_t pixel;
		logic              known;
		hsv2rgb_pkg::rgb_t rgb;
	} dir_row_t;

	localparam int NUM_ROWS = 24;
	localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		{13'd0,    8'd0,   8'd0,   KNOWN,     8'd0,   8'd0,   8'd0},
		{13'd0,    8'd255, 8'd255, KNOWN,     8'd255, 8'd0,   8'd0},
		{13'd960,  8'd255, 8'd255, KNOWN,     8'd255, 8'd255, 8'd0},
		{13'd1920, 8'd255, 8'd255, KNOWN,     8'd0,   8'd255, 8'd0},
		{13'd2880, 8'd255, 8'd255, KNOWN,     8'd0,   8'd255, 8'd255},
		{13'd3840, 8'd255, 8'd255, KNOWN,     8'd0,   8'd0,   8'd255},
		{13'd4800, 8'd255, 8'd255, KNOWN,     8'd255, 8'd0,   8'd255},
		{13'd5759, 8'd255, 8'd255, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd5760, 8'd255, 8'd255, KNOWN,     8'd255, 8'd0,   8'd0},
		{13'd8191, 8'd255, 8'd255, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd6720, 8'd255, 8'd255, KNOWN,     8'd255, 8'd255, 8'd0},
		{13'd1234, 8'd0,   8'd255, KNOWN,     8'd255, 8'd255, 8'd255},
		{13'd4321, 8'd0,   8'd128, KNOWN,     8'd128, 8'd128, 8'd128},
		{13'd480,  8'd255, 8'd1,   KNOWN,     8'd1,   8'd1,   8'd0},
		{13'd480,  8'd255, 8'd255, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd959,  8'd255, 8'd255, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd961,  8'd200, 8'd100, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd2879, 8'd1,   8'd1,   PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd3000, 8'd255, 8'd0,   KNOWN,     8'd0,   8'd0,   8'd0},
		{13'd5000, 8'd128, 8'd200, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd7000, 8'd77,  8'd33,  PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd8191, 8'd0,   8'd0,   KNOWN,     8'd0,   8'd0,   8'd0},
		{13'd1,    8'd1,   8'd254, PREDICTED, 8'd0,   8'd0,   8'd0},
		{13'd4096, 8'd170, 8'd85,  PREDICTED, 8'd0,   8'd0,   8'd0}
	};

	logic clk;
	logic arst_n;

	hsv2rgb_stream_if #(.payload_t(hsv2rgb_pkg::hsv_t)) hsv_bus ();
	hsv2rgb_stream_if #(.payload_t(hsv2rgb_pkg::rgb_t)) rgb_bus ();

	hsv_to_rgb_converter_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_bus),
		.rgb    (rgb_bus)
	);

	hsv2rgb_pkg::rgb_t pending_rgb [$];
	int   mismatches;
	int   rgb_count;
	int   send_idle_pct;
	int   stall_pct;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] scale_channel(input int unsigned num);
		int unsigned q;
		q = (num + hsv2rgb_pkg::HALF_DENOM) / hsv2rgb_pkg::DENOM;
		if (q > hsv2rgb_pkg::CHAN_MAX) begin
			q = hsv2rgb_pkg::CHAN_MAX;
		end
		return hsv2rgb_pkg::CHAN_W'(q);
	endfunction

	function automatic hsv2rgb_pkg::rgb_t predict_rgb(input hsv2rgb_pkg::hsv_t px);
		int unsigned                      hue, pos, k, prod, cn, xn, mn, r1, g1, b1;
		logic [hsv2rgb_pkg::SECTOR_W-1:0] sector;
		hsv2rgb_pkg::rgb_t                rgb;
		hue = px.hue;
		if (hue >= hsv2rgb_pkg::HUE_FULL) begin
			hue = hue - hsv2rgb_pkg::HUE_FULL;
		end
		sector = hsv2rgb_pkg::SECTOR_W'(hue / hsv2rgb_pkg::SECTOR_LEN);
		pos = hue % hsv2rgb_pkg::SECTOR_LEN;
		k = sector[0] ? hsv2rgb_pkg::SECTOR_LEN - pos : pos;
		prod = int'(px.brightness) * int'(px.saturation);
		cn = prod * hsv2rgb_pkg::SECTOR_LEN;
		xn = prod * k;
		mn = (hsv2rgb_pkg::CHAN_MAX * int'(px.brightness) - prod) * hsv2rgb_pkg::SECTOR_LEN;
		case (sector)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				r1 = cn; g1 = xn; b1 = 0;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				r1 = xn; g1 = cn; b1 = 0;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				r1 = 0; g1 = cn; b1 = xn;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				r1 = 0; g1 = xn; b1 = cn;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				r1 = xn; g1 = 0; b1 = cn;
			end
			default: begin
				r1 = cn; g1 = 0; b1 = xn;
			end
		endcase
		rgb.red   = scale_channel(r1 + mn);
		rgb.green = scale_channel(g1 + mn);
		rgb.blue  = scale_channel(b1 + mn);
		return rgb;
	endfunction

	function automatic hsv2rgb_pkg::hsv_t random_pixel();
		hsv2rgb_pkg::hsv_t px;
		int unsigned       pick;
		int unsigned       n;
		pick = $urandom_range(0, 9);
		px.hue        = hsv2rgb_pkg::HUE_W'($urandom_range(0, hsv2rgb_pkg::HUE_FULL - 1));
		px.saturation = hsv2rgb_pkg::CHAN_W'($urandom);
		px.brightness = hsv2rgb_pkg::CHAN_W'($urandom);
		case (pick)
			0: px.hue = hsv2rgb_pkg::HUE_W'($urandom_range(hsv2rgb_pkg::HUE_FULL,
				(1 << hsv2rgb_pkg::HUE_W) - 1));
			1: px.hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, 8191));
			2: px.hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, hsv2rgb_pkg::NUM_SECTORS)
				* hsv2rgb_pkg::SECTOR_LEN + $urandom_range(0, 2) - 1);
			3: begin
				n = $urandom_range(0, 3);
				px.saturation = (n < 2) ? hsv2rgb_pkg::CHAN_W'(n)
					: hsv2rgb_pkg::CHAN_W'(252 + n);
				n = $urandom_range(0, 3);
				px.brightness = (n < 2) ? hsv2rgb_pkg::CHAN_W'(n)
					: hsv2rgb_pkg::CHAN_W'(252 + n);
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR t=%0t %s", $realtime, msg);
		mismatches++;
	endtask

	// Call at a falling edge; returns at a falling edge.
	task automatic send_pixel(input hsv2rgb_pkg::hsv_t px, input hsv2rgb_pkg::rgb_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			hsv_bus.valid <= 1'b0;
			@(negedge clk);
		end
		hsv_bus.valid <= 1'b1;
		hsv_bus.data  <= px;
		do @(posedge clk); while (!hsv_bus.ready);
		pending_rgb.push_back(want);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		hsv_bus.valid <= 1'b0;
		do @(negedge clk); while (pending_rgb.size() != 0);
	endtask

	always @(negedge clk) begin
		rgb_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		hsv2rgb_pkg::rgb_t got;
		hsv2rgb_pkg::rgb_t want;
		if (arst_n && rgb_bus.valid && rgb_bus.ready) begin
			got = rgb_bus.data;
			if (pending_rgb.size() == 0) begin
				report_mismatch($sformatf("unexpected word %0d: %h", rgb_count, got));
			end else begin
				want = pending_rgb.pop_front();
				if (got.red !== want.red)
					report_mismatch($sformatf("word %0d red %0d want %0d",
						rgb_count, got.red, want.red));
				if (got.green !== want.green)
					report_mismatch($sformatf("word %0d green %0d want %0d",
						rgb_count, got.green, want.green));
				if (got.blue !== want.blue)
					report_mismatch($sformatf("word %0d blue %0d want %0d",
						rgb_count, got.blue, want.blue));
			end
			rgb_count++;
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("FAIL hsv_to_rgb_converter_top");
		$finish;
	end

	initial begin
		int                phase;
		int                wait_cycles;
		hsv2rgb_pkg::hsv_t px;
		mismatches    = 0;
		rgb_count     = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		arst_n        = 1'b0;
		hsv_bus.valid = 1'b0;
		hsv_bus.data  = '0;
		rgb_bus.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			px = DIRECTED_ROWS[i].pixel;
			if (DIRECTED_ROWS[i].known)
				send_pixel(px, DIRECTED_ROWS[i].rgb);
			else
				send_pixel(px, predict_rgb(px));
		end
		hold_until_drained();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 68; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 68; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				if ($urandom_range(0, 299) == 0)
					hold_until_drained();
				px = random_pixel();
				send_pixel(px, predict_rgb(px));
			end
			hold_until_drained();
		end

		hsv_bus.valid <= 1'b0;
		for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && pending_rgb.size() != 0;
				wait_cycles++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_rgb.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", pending_rgb.size()));
		if (mismatches == 0) begin
			$display("PASS hsv_to_rgb_converter_top");
		end else begin
			$display("FAIL hsv_to_rgb_converter_top");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_stream_if.sv
rtl/hsv2rgb_sector.sv
rtl/hsv2rgb_product.sv
rtl/hsv2rgb_channel.sv
rtl/hsv2rgb_converter_top.sv
test/testbench.sv
